// ===== hw/rtl/avwm_pkg.sv =====
package avwm_pkg;

  localparam int unsigned DATA_W = 16;
  localparam int unsigned IDX_W  = 3;
  localparam logic [DATA_W-1:0] MV_MAX = 16'hFFFF;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_EVAL   = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    CODE_OK     = 2'd0,
    CODE_NOINIT = 2'd1,
    CODE_RANGE  = 2'd2
  } code_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_RUN  = 2'd1,
    MODE_DIAG = 2'd2
  } mode_t;

  localparam logic [1:0] MODE_BAD = 2'd3;

  typedef enum logic [IDX_W-1:0] {
    REG_GAIN   = 3'd0,
    REG_OFFSET = 3'd1,
    REG_UNDER  = 3'd2,
    REG_OVER   = 3'd3,
    REG_HYST   = 3'd4,
    REG_LIMIT  = 3'd5,
    REG_MODE   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic        [DATA_W-1:0] gain;
    logic signed [DATA_W-1:0] offset_mv;
    logic        [DATA_W-1:0] under_th;
    logic        [DATA_W-1:0] over_th;
    logic        [DATA_W-1:0] hyst;
    logic        [DATA_W-1:0] raw_limit;
    mode_t                    mode;
  } cfg_t;

  // side effects of a mode register write on monitor state
  typedef struct packed {
    logic set_err;
    logic clr_inv;
  } mode_evt_t;

endpackage

// ===== hw/rtl/avwm_cfg.sv =====
module avwm_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                wr_en,
  input  logic [avwm_pkg::IDX_W-1:0]          wr_idx,
  input  logic [avwm_pkg::DATA_W-1:0]         wr_data,
  output avwm_pkg::cfg_t                      cfg,
  output avwm_pkg::mode_evt_t                 evt
);
  import avwm_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt     = cfg_r;
    evt.set_err = 1'b0;
    evt.clr_inv = 1'b0;
    if (wr_en) begin
      unique case (reg_idx_t'(wr_idx))
        REG_GAIN:   cfg_nxt.gain      = wr_data;
        REG_OFFSET: cfg_nxt.offset_mv = $signed(wr_data);
        REG_UNDER:  cfg_nxt.under_th  = wr_data;
        REG_OVER:   cfg_nxt.over_th   = wr_data;
        REG_HYST:   cfg_nxt.hyst      = wr_data;
        REG_LIMIT:  cfg_nxt.raw_limit = wr_data;
        REG_MODE: begin
          // no mode change before a limit is set, and code 3 is rejected
          if ((cfg_r.raw_limit == '0) || (wr_data[1:0] == MODE_BAD)) begin
            evt.set_err = 1'b1;
          end else begin
            cfg_nxt.mode = mode_t'(wr_data[1:0]);
            evt.clr_inv  = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain      <= 16'd1;
      cfg_r.offset_mv <= '0;
      cfg_r.under_th  <= '0;
      cfg_r.over_th   <= MV_MAX;
      cfg_r.hyst      <= '0;
      cfg_r.raw_limit <= 16'd4095;
      cfg_r.mode      <= MODE_IDLE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hw/rtl/avwm_scale.sv =====
module avwm_scale (
  input  logic        [avwm_pkg::DATA_W-1:0] raw,
  input  logic        [avwm_pkg::DATA_W-1:0] gain,
  input  logic signed [avwm_pkg::DATA_W-1:0] offset_mv,
  output logic        [avwm_pkg::DATA_W-1:0] mv
);
  import avwm_pkg::*;

  localparam int unsigned PROD_W = 2 * DATA_W;
  localparam int unsigned SUM_W  = PROD_W + 2;

  logic        [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  sum;

  assign prod = raw * gain;
  assign sum  = $signed({2'b00, prod}) + SUM_W'(offset_mv);

  // clamp to 0..MV_MAX
  always_comb begin
    if (sum[SUM_W-1]) begin
      mv = '0;
    end else if (|sum[SUM_W-2:DATA_W]) begin
      mv = MV_MAX;
    end else begin
      mv = sum[DATA_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/avwm_hyst.sv =====
module avwm_hyst (
  input  logic [avwm_pkg::DATA_W-1:0] volt,
  input  avwm_pkg::cfg_t              cfg,
  input  logic                        under_act,
  input  logic                        over_act,
  output logic                        under_nxt,
  output logic                        over_nxt
);
  import avwm_pkg::*;

  logic [DATA_W-1:0] under_clear;
  logic [DATA_W-1:0] over_clear;

  // clear levels wrap at 16 bits
  assign under_clear = cfg.under_th + cfg.hyst;
  assign over_clear  = cfg.over_th - cfg.hyst;

  always_comb begin
    under_nxt = under_act;
    if (!under_act && (volt <= cfg.under_th)) begin
      under_nxt = 1'b1;
    end else if (under_act && (volt >= under_clear)) begin
      under_nxt = 1'b0;
    end
    over_nxt = over_act;
    if (!over_act && (volt >= cfg.over_th)) begin
      over_nxt = 1'b1;
    end else if (over_act && (volt <= over_clear)) begin
      over_nxt = 1'b0;
    end
  end

endmodule

// ===== hw/rtl/adc_voltage_window_monitor_unit.sv =====
// an item goes from input transfer through the input register and then the result register
// to result transfer; throughput: one item per cycle while out_stall is low
// scale multiply-add and window compares share one stage
// a stalled result register holds one item while the input register holds the next
// reset (rst_n low, synchronous) clears stored sample, voltage and all flags and
// loads register defaults: gain 1, over threshold 65535, raw limit 4095, mode idle
module adc_voltage_window_monitor_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_cmd,
  input  logic [avwm_pkg::DATA_W-1:0]      in_raw_sample,
  output logic                             out_valid,
  input  logic                             out_stall,
  output avwm_pkg::code_t                  out_code,
  output logic [avwm_pkg::DATA_W-1:0]      out_voltage_mv,
  output logic [avwm_pkg::DATA_W-1:0]      out_last_raw,
  output logic                             out_under_flag,
  output logic                             out_over_flag,
  output logic                             out_error_flag,
  output logic                             out_invalid_flag,
  output logic                             out_ready_flag,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [avwm_pkg::IDX_W-1:0]       cfg_index,
  input  logic [avwm_pkg::DATA_W-1:0]      cfg_wdata
);
  import avwm_pkg::*;

  cfg_t       cfg;
  mode_evt_t  evt;

  logic              s1_valid_r, s1_valid_nxt;
  cmd_t              s1_cmd_r;
  logic [DATA_W-1:0] s1_raw_r;

  logic [DATA_W-1:0] raw_st_r, raw_st_nxt;
  logic [DATA_W-1:0] volt_st_r, volt_st_nxt;
  logic              under_r, under_nxt;
  logic              over_r, over_nxt;
  logic              err_r, err_nxt;
  logic              inv_r, inv_nxt;

  logic              res_valid_r;
  code_t             res_code_r, res_code_nxt;
  logic [DATA_W-1:0] res_volt_r;
  logic [DATA_W-1:0] res_raw_r;
  logic              res_under_r, res_over_r, res_err_r, res_inv_r, res_rdy_r;

  logic              out_free;
  logic              adv;
  logic              in_xfer;
  logic              ready;
  logic [DATA_W-1:0] scaled_mv;
  logic              hy_under, hy_over;

  assign cfg_ready = 1'b1;

  avwm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_idx  (cfg_index),
    .wr_data (cfg_wdata),
    .cfg     (cfg),
    .evt     (evt)
  );

  avwm_scale u_scale (
    .raw       (s1_raw_r),
    .gain      (cfg.gain),
    .offset_mv (cfg.offset_mv),
    .mv        (scaled_mv)
  );

  avwm_hyst u_hyst (
    .volt      (volt_st_r),
    .cfg       (cfg),
    .under_act (under_r),
    .over_act  (over_r),
    .under_nxt (hy_under),
    .over_nxt  (hy_over)
  );

  // result register frees up when empty or taken this cycle
  assign out_free = !res_valid_r || !out_stall;
  assign adv      = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_xfer  = in_valid && !in_stall;
  assign ready    = (cfg.raw_limit != '0);

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    raw_st_nxt   = raw_st_r;
    volt_st_nxt  = volt_st_r;
    under_nxt    = under_r;
    over_nxt     = over_r;
    err_nxt      = err_r;
    inv_nxt      = inv_r;
    res_code_nxt = CODE_OK;
    if (adv) begin
      if (!ready) begin
        res_code_nxt = CODE_NOINIT;
        if (s1_cmd_r == CMD_SAMPLE) begin
          err_nxt = 1'b1;
        end
      end else if (s1_cmd_r == CMD_SAMPLE) begin
        if (s1_raw_r > cfg.raw_limit) begin
          err_nxt      = 1'b1;
          inv_nxt      = 1'b1;
          res_code_nxt = CODE_RANGE;
        end else begin
          raw_st_nxt  = s1_raw_r;
          volt_st_nxt = scaled_mv;
          inv_nxt     = 1'b0;
        end
      end else if ((cfg.mode == MODE_RUN) || (cfg.mode == MODE_DIAG)) begin
        under_nxt = hy_under;
        over_nxt  = hy_over;
      end
    end
    // mode writes must only come while idle; the block itself does not enforce this
    if (evt.set_err) begin
      err_nxt = 1'b1;
    end
    if (evt.clr_inv) begin
      inv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      res_valid_r <= 1'b0;
      raw_st_r    <= '0;
      volt_st_r   <= '0;
      under_r     <= 1'b0;
      over_r      <= 1'b0;
      err_r       <= 1'b0;
      inv_r       <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (out_free) begin
        res_valid_r <= s1_valid_r;
      end
      raw_st_r  <= raw_st_nxt;
      volt_st_r <= volt_st_nxt;
      under_r   <= under_nxt;
      over_r    <= over_nxt;
      err_r     <= err_nxt;
      inv_r     <= inv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_cmd_r <= cmd_t'(in_cmd);
      s1_raw_r <= in_raw_sample;
    end
    if (adv) begin
      res_code_r  <= res_code_nxt;
      res_volt_r  <= ready ? volt_st_nxt : '0;
      res_raw_r   <= raw_st_nxt;
      res_under_r <= under_nxt;
      res_over_r  <= over_nxt;
      res_err_r   <= err_nxt;
      res_inv_r   <= inv_nxt;
      res_rdy_r   <= ready;
    end
  end

  assign out_valid        = res_valid_r;
  assign out_code         = res_code_r;
  assign out_voltage_mv   = res_volt_r;
  assign out_last_raw     = res_raw_r;
  assign out_under_flag   = res_under_r;
  assign out_over_flag    = res_over_r;
  assign out_error_flag   = res_err_r;
  assign out_invalid_flag = res_inv_r;
  assign out_ready_flag   = res_rdy_r;

endmodule

// ===== hw/rtl/avwm_chk.sv =====
module avwm_chk (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  avwm_pkg::code_t                  out_code,
  input  logic [avwm_pkg::DATA_W-1:0]      out_voltage_mv,
  input  logic [avwm_pkg::DATA_W-1:0]      out_last_raw,
  input  logic                             out_error_flag,
  input  logic                             out_invalid_flag,
  input  logic                             out_ready_flag
);
  import avwm_pkg::*;

  logic err_seen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_seen_r <= 1'b0;
    end else if (out_valid && out_error_flag) begin
      err_seen_r <= 1'b1;
    end
  end

  // error is sticky across results until reset
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && err_seen_r |-> out_error_flag)
    else $error("error flag dropped after being reported");

  a_noinit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready_flag |-> (out_voltage_mv == '0) && (out_code == CODE_NOINIT))
    else $error("uninitialized result with voltage or wrong code");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_code == CODE_RANGE)
      |-> out_invalid_flag && out_error_flag && out_ready_flag)
    else $error("out of range result without invalid and error flags");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_code) && $stable(out_voltage_mv)
      && $stable(out_last_raw) && $stable(out_error_flag))
    else $error("stalled result changed");

endmodule

bind adc_voltage_window_monitor_unit avwm_chk u_avwm_chk (.*);
